// File: src/qrm_pkg.sv
// shared constants and the beat type passed from the front end to the back end
`default_nettype none
package qrm_pkg;

  localparam int COMP_W  = 16;                // component and entry width
  localparam int FRAC_W  = 14;                // fraction bits, also divide steps
  localparam int THR_W   = 14;                // clean threshold width
  localparam int LANES   = 9;                 // matrix entries per beat
  localparam int PROD_W  = 2 * COMP_W;        // signed product width
  localparam int SUM_W   = PROD_W + 2;        // signed numerator before magnitude
  localparam int MAG_W   = PROD_W + 1;        // numerator magnitude width
  localparam int DEN_W   = PROD_W + 1;        // quadrance width
  localparam int QUO_W   = FRAC_W + 2;        // quotient width, holds one plus round
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one classified quaternion waiting for division
  typedef struct packed {
    logic                         zero;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
    logic [DEN_W-1:0]             den;
  } work_t;

endpackage
`default_nettype wire

// File: src/qrm_front.sv
// front end: takes quaternion beats, forms products, numerators and quadrance
`default_nettype none
module qrm_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [4*qrm_pkg::COMP_W-1:0]          in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output qrm_pkg::work_t                             out_work
);

  logic signed [qrm_pkg::COMP_W-1:0] w, x, y, z;
  logic                              halve;
  logic                              adv;

  // stage one products
  logic                              v1;
  logic signed [qrm_pkg::PROD_W-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;

  // stage two result
  logic                              v2;
  qrm_pkg::work_t                    work;
  qrm_pkg::work_t                    work_next;

  logic signed [qrm_pkg::SUM_W-1:0]  num [qrm_pkg::LANES];
  logic signed [qrm_pkg::SUM_W-1:0]  quad;

  assign adv       = !v2 || out_ready;
  assign in_ready  = adv;
  assign out_valid = v2;
  assign out_work  = work;

  // drop a common factor of two
  always_comb begin
    halve = !(in_data[0] | in_data[qrm_pkg::COMP_W] | in_data[2*qrm_pkg::COMP_W] |
              in_data[3*qrm_pkg::COMP_W]);
    w = in_data[0 +: qrm_pkg::COMP_W];
    x = in_data[qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    y = in_data[2*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    z = in_data[3*qrm_pkg::COMP_W +: qrm_pkg::COMP_W];
    if (halve) begin
      w = w >>> 1;
      x = x >>> 1;
      y = y >>> 1;
      z = z >>> 1;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= w * w;  xx <= x * x;  yy <= y * y;  zz <= z * z;
      xy <= x * y;  zw <= z * w;  xz <= x * z;
      yw <= y * w;  yz <= y * z;  xw <= x * w;
    end
  end

  // numerators and quadrance, zero quaternion mapped to identity
  always_comb begin
    quad = qrm_pkg::SUM_W'(ww) + qrm_pkg::SUM_W'(xx) + qrm_pkg::SUM_W'(yy) +
           qrm_pkg::SUM_W'(zz);
    num[0] = qrm_pkg::SUM_W'(ww) + qrm_pkg::SUM_W'(xx) - qrm_pkg::SUM_W'(yy) -
             qrm_pkg::SUM_W'(zz);
    num[1] = (qrm_pkg::SUM_W'(xy) + qrm_pkg::SUM_W'(zw)) <<< 1;
    num[2] = (qrm_pkg::SUM_W'(xz) - qrm_pkg::SUM_W'(yw)) <<< 1;
    num[3] = (qrm_pkg::SUM_W'(xy) - qrm_pkg::SUM_W'(zw)) <<< 1;
    num[4] = qrm_pkg::SUM_W'(ww) + qrm_pkg::SUM_W'(yy) - qrm_pkg::SUM_W'(xx) -
             qrm_pkg::SUM_W'(zz);
    num[5] = (qrm_pkg::SUM_W'(yz) + qrm_pkg::SUM_W'(xw)) <<< 1;
    num[6] = (qrm_pkg::SUM_W'(xz) + qrm_pkg::SUM_W'(yw)) <<< 1;
    num[7] = (qrm_pkg::SUM_W'(yz) - qrm_pkg::SUM_W'(xw)) <<< 1;
    num[8] = qrm_pkg::SUM_W'(ww) + qrm_pkg::SUM_W'(zz) - qrm_pkg::SUM_W'(xx) -
             qrm_pkg::SUM_W'(yy);
    work_next.zero = (quad == '0);
    work_next.den  = quad[qrm_pkg::DEN_W-1:0];
    for (int i = 0; i < qrm_pkg::LANES; i++) begin
      work_next.neg[i] = num[i][qrm_pkg::SUM_W-1];
      work_next.mag[i] = num[i][qrm_pkg::SUM_W-1] ?
                         qrm_pkg::MAG_W'(-num[i]) : qrm_pkg::MAG_W'(num[i]);
    end
    if (work_next.zero) begin
      work_next.den = qrm_pkg::DEN_W'(1);
      work_next.neg = '0;
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
        work_next.mag[i] = (i == 0 || i == 4 || i == 8) ? qrm_pkg::MAG_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      work <= work_next;
    end
  end

endmodule
`default_nettype wire

// File: src/qrm_fifo.sv
// short queue between front and back end
`default_nettype none
module qrm_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire qrm_pkg::work_t push_data,
  output logic                full,
  input  wire logic           pop,
  output qrm_pkg::work_t      pop_data,
  output logic                empty
);

  qrm_pkg::work_t               mem [qrm_pkg::FIFO_DEPTH];
  logic [qrm_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [qrm_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [qrm_pkg::FIFO_AW:0]    count;

  assign full     = (count == (qrm_pkg::FIFO_AW+1)'(qrm_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (qrm_pkg::FIFO_AW+1)'(push && !full) -
               (qrm_pkg::FIFO_AW+1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// File: src/qrm_back.sv
// back end: pipelined restoring division per entry, rounding, saturation and clean
`default_nettype none
module qrm_back (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic [qrm_pkg::THR_W-1:0]                 clean_threshold,
  input  wire logic                                      in_avail,
  output logic                                           in_pop,
  input  wire qrm_pkg::work_t                            in_work,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [qrm_pkg::LANES*qrm_pkg::COMP_W-1:0]      out_data,
  output logic                                           out_zero
);

  localparam int ST = qrm_pkg::FRAC_W;

  logic adv;

  logic                           sv   [ST+1];
  logic                           sz   [ST+1];
  logic [qrm_pkg::DEN_W-1:0]      sd   [ST+1];
  logic [qrm_pkg::LANES-1:0]      sneg [ST+1];
  logic [qrm_pkg::DEN_W-1:0]      sr   [ST+1][qrm_pkg::LANES];
  logic [qrm_pkg::QUO_W-1:0]      sq   [ST+1][qrm_pkg::LANES];

  logic [qrm_pkg::MAG_W-1:0]      nn   [qrm_pkg::LANES];
  logic [qrm_pkg::DEN_W:0]        dbl  [ST+1][qrm_pkg::LANES];
  logic [qrm_pkg::QUO_W-1:0]      qf   [qrm_pkg::LANES];
  logic [qrm_pkg::COMP_W-1:0]     ent  [qrm_pkg::LANES];

  assign adv    = !out_valid || out_ready;
  assign in_pop = adv && in_avail;

  // clamp numerator to denominator
  always_comb begin
    for (int i = 0; i < qrm_pkg::LANES; i++) begin
      nn[i] = (in_work.mag[i] > in_work.den) ? in_work.den : in_work.mag[i];
    end
  end

  // doubled remainders for each stage
  always_comb begin
    for (int k = 0; k <= ST; k++) begin
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
        dbl[k][i] = {sr[k][i], 1'b0};
      end
    end
  end

  // valid bits of the divide pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ST; k++) begin
        sv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      sv[0] <= in_avail;
      for (int k = 1; k <= ST; k++) begin
        sv[k] <= sv[k-1];
      end
      out_valid <= sv[ST];
    end
  end

  // divide stages, one quotient bit each
  always_ff @(posedge clk) begin
    if (adv) begin
      sz[0]   <= in_work.zero;
      sd[0]   <= in_work.den;
      sneg[0] <= in_work.neg;
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
        sq[0][i] <= (nn[i] == in_work.den) ? qrm_pkg::QUO_W'(1) : '0;
        sr[0][i] <= (nn[i] == in_work.den) ? '0 : nn[i];
      end
      for (int k = 1; k <= ST; k++) begin
        sz[k]   <= sz[k-1];
        sd[k]   <= sd[k-1];
        sneg[k] <= sneg[k-1];
        for (int i = 0; i < qrm_pkg::LANES; i++) begin
          if (dbl[k-1][i] >= {1'b0, sd[k-1]}) begin
            sr[k][i] <= qrm_pkg::DEN_W'(dbl[k-1][i] - {1'b0, sd[k-1]});
            sq[k][i] <= {sq[k-1][i][qrm_pkg::QUO_W-2:0], 1'b1};
          end else begin
            sr[k][i] <= dbl[k-1][i][qrm_pkg::DEN_W-1:0];
            sq[k][i] <= {sq[k-1][i][qrm_pkg::QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round half up, saturate to one, clean small magnitudes, apply sign
  always_comb begin
    for (int i = 0; i < qrm_pkg::LANES; i++) begin
      qf[i] = sq[ST][i] + qrm_pkg::QUO_W'(dbl[ST][i] >= {1'b0, sd[ST]});
      if (qf[i] > qrm_pkg::QUO_W'(1 << qrm_pkg::FRAC_W)) begin
        qf[i] = qrm_pkg::QUO_W'(1 << qrm_pkg::FRAC_W);
      end
      if (qf[i] < qrm_pkg::QUO_W'(clean_threshold)) begin
        qf[i] = '0;
      end
      ent[i] = sneg[ST][i] ? qrm_pkg::COMP_W'(-qf[i]) : qrm_pkg::COMP_W'(qf[i]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_zero <= sz[ST];
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
        out_data[i*qrm_pkg::COMP_W +: qrm_pkg::COMP_W] <= ent[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/quaternion_to_rotation_matrix_unit.sv
// top level: quaternion to normalized 3x3 rotation matrix
// a beat passes the front end product and numerator registers, the queue, the divide stages and the output register
// throughput: one beat per cycle while m_tready holds, set by the fully pipelined 14-step divide in the back end
// a four-entry queue between front and back end absorbs output stalls
// rst is synchronous and clears all valid bits and the queue; clean_threshold resets to 16
`default_nettype none
module quaternion_to_rotation_matrix_unit (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_wr_en,
  input  wire logic [qrm_pkg::THR_W-1:0]                cfg_wr_data,
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  // quat_w, quat_x, quat_y, quat_z
  input  wire logic [4*qrm_pkg::COMP_W-1:0]             s_tdata,
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  // entry_0, entry_1, entry_2, entry_4, entry_5, entry_6, entry_8, entry_9, entry_10
  output logic [qrm_pkg::LANES*qrm_pkg::COMP_W-1:0]     m_tdata,
  // zero_input
  output logic                                          m_tuser
);

  logic [qrm_pkg::THR_W-1:0] clean_threshold;
  logic                      f_valid;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  qrm_pkg::work_t            f_work;
  qrm_pkg::work_t            q_work;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      clean_threshold <= qrm_pkg::THR_W'(16);
    end else if (cfg_wr_en) begin
      clean_threshold <= cfg_wr_data;
    end
  end

  qrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_work  (f_work)
  );

  qrm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_work),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_work),
    .empty     (q_empty)
  );

  qrm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .clean_threshold (clean_threshold),
    .in_avail        (!q_empty),
    .in_pop          (q_pop),
    .in_work         (q_work),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_data        (m_tdata),
    .out_zero        (m_tuser)
  );

  // a zero quaternion gives one on the first diagonal entry
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h4000)
    else $error("zero quaternion without identity diagonal");

  // the second entry never exceeds one in magnitude
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sh4000 &&
                  $signed(m_tdata[31:16]) >= -16'sh4000))
    else $error("entry out of range");

  // queue full and empty flags are never set together
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_empty)
    else $error("queue flags inconsistent");

endmodule
`default_nettype wire
